>>> hdl/rcfr_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// rcfr_pkg
// Shared types and constants for the RC channel frame receiver.
// -----------------------------------------------------------------------------
package rcfr_pkg;

   localparam int NUM_CHANNELS = 14;
   localparam int CH_W         = 4;
   localparam int FRAME_BYTES  = 32;
   localparam int FILL_W       = $clog2(FRAME_BYTES);

   localparam logic [7:0]  HDR0 = 8'h20;
   localparam logic [7:0]  HDR1 = 8'h40;
   localparam logic [FILL_W-1:0] CSUM_POS = FILL_W'(FRAME_BYTES - 2);
   localparam logic [FILL_W-1:0] LAST_POS = FILL_W'(FRAME_BYTES - 1);

   localparam logic [15:0] TIMEOUT_RST = 16'd1000;
   localparam logic [16:0] QUIET_MAX   = 17'h1FFFF;

   localparam logic [15:0] PULSE_MIN = 16'd1000;
   localparam logic [15:0] PULSE_MAX = 16'd2000;
   localparam logic [10:0] PULSE_MID = 11'd1500;
   localparam logic [23:0] SCALE_DEN = 24'd500;
   localparam logic [23:0] HALF_DEN  = 24'd250;
   localparam logic [15:0] VALUE_MAX = 16'd32767;

   // ceil(2^33 / 500): exact floor division of 24-bit products by 500
   localparam logic [24:0] RECIP       = 25'd17179870;
   localparam int          RECIP_SHIFT = 33;

   typedef enum logic [1:0] {
      KIND_CHANNEL  = 2'd0,
      KIND_CONNECT  = 2'd1,
      KIND_FAILSAFE = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_LO,
      ST_RD_HI,
      ST_CAP,
      ST_PROD,
      ST_QUOT,
      ST_ROUND,
      ST_EMIT_CH,
      ST_EMIT_CONN,
      ST_EMIT_FAIL
   } state_type;

   typedef struct packed {
      logic     accept;
      logic     rd_hi;
      logic     cap_lo;
      logic     cap_hi;
      logic     ch_clr;
      logic     ch_inc;
      logic     load_out;
      kind_type out_kind;
      logic     out_last;
   } cmd_type;

   typedef struct packed {
      logic frame_good;
      logic fail_fire;
      logic conn_pending;
      logic out_free;
      logic ch_last;
   } status_type;

endpackage
`default_nettype wire

>>> hdl/rcfr_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// rcfr_req_if / rcfr_rsp_if
// Valid/ready channels for input items and result transactions.
// -----------------------------------------------------------------------------
interface rcfr_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] rx_byte;

   modport source (output valid, output op, output rx_byte, input ready);
   modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface rcfr_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [3:0]         channel;
   logic signed [15:0] value;
   logic               last;

   modport source (output valid, output kind, output channel, output value,
                   output last, input ready);
   modport sink   (input valid, input kind, input channel, input value,
                   input last, output ready);
endinterface
`default_nettype wire

>>> hdl/rcfr_ram.sv
`default_nettype none
// -----------------------------------------------------------------------------
// rcfr_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module rcfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hdl/rcfr_ctrl.sv
`default_nettype none
// -----------------------------------------------------------------------------
// rcfr_ctrl
// Sequencer: accepts items, walks the channel loop and issues result loads.
// -----------------------------------------------------------------------------
module rcfr_ctrl import rcfr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.out_kind = KIND_CHANNEL;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               if (status.fail_fire) begin
                  state_in = ST_EMIT_FAIL;
               end else if (status.frame_good) begin
                  cmd.ch_clr = 1'b1;
                  state_in   = ST_RD_LO;
               end
            end
         end
         ST_RD_LO: begin
            state_in = ST_RD_HI;
         end
         ST_RD_HI: begin
            cmd.rd_hi  = 1'b1;
            cmd.cap_lo = 1'b1;
            state_in   = ST_CAP;
         end
         ST_CAP: begin
            cmd.cap_hi = 1'b1;
            state_in   = ST_PROD;
         end
         ST_PROD: begin
            state_in = ST_QUOT;
         end
         ST_QUOT: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            state_in = ST_EMIT_CH;
         end
         ST_EMIT_CH: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_kind = KIND_CHANNEL;
               cmd.out_last = status.ch_last && !status.conn_pending;
               if (!status.ch_last) begin
                  cmd.ch_inc = 1'b1;
                  state_in   = ST_RD_LO;
               end else if (status.conn_pending) begin
                  state_in = ST_EMIT_CONN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT_CONN: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_kind = KIND_CONNECT;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_EMIT_FAIL: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_kind = KIND_FAILSAFE;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> hdl/rcfr_dp.sv
`default_nettype none
// -----------------------------------------------------------------------------
// rcfr_dp
// Datapath: frame sync and checksum, link timer, pulse scaling, result register.
// -----------------------------------------------------------------------------
module rcfr_dp import rcfr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               req_op,
   input  logic [7:0]         req_rx_byte,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [1:0]         rsp_kind,
   output logic [3:0]         rsp_channel,
   output logic signed [15:0] rsp_value,
   output logic               rsp_last
);

   logic [15:0]       timeout_ff;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [15:0]       sum_ff, sum_in;
   logic [7:0]        prev_ff;
   logic              link_up_ff;
   logic              conn_pending_ff;
   logic [16:0]       quiet_ff, quiet_in;
   logic [CH_W-1:0]   ch_ff;

   logic              byte_acc;
   logic              tick_acc;
   logic              csum_match;
   logic [FILL_W-1:0] rd_addr;
   logic [7:0]        rd_data;

   logic [7:0]        lo_ff;
   logic [15:0]       pulse;
   logic [10:0]       clamped;
   logic              neg_ff;
   logic [8:0]        mag_ff;
   logic [23:0]       prod_ff;
   logic [48:0]       recip_prod;
   logic [14:0]       quot_ff;
   logic [23:0]       rem;
   logic [15:0]       rounded;
   logic [15:0]       val_ff;

   logic              rsp_valid_ff;
   kind_type          kind_ff;
   logic [CH_W-1:0]   channel_ff;
   logic [15:0]       value_ff;
   logic              last_ff;

   assign byte_acc = cmd.accept && !req_op;
   assign tick_acc = cmd.accept && req_op;

   // frame sync and running checksum
   always_comb begin
      fill_in    = fill_ff;
      sum_in     = sum_ff;
      csum_match = 1'b0;
      if (fill_ff == '0) begin
         if (req_rx_byte == HDR0) begin
            fill_in = FILL_W'(1);
            sum_in  = {8'h00, HDR0};
         end
      end else if (fill_ff == FILL_W'(1)) begin
         if (req_rx_byte == HDR1) begin
            fill_in = FILL_W'(2);
            sum_in  = sum_ff + {8'h00, req_rx_byte};
         end else if (req_rx_byte == HDR0) begin
            fill_in = FILL_W'(1);
            sum_in  = {8'h00, HDR0};
         end else begin
            fill_in = '0;
         end
      end else begin
         if (fill_ff < CSUM_POS) begin
            sum_in = sum_ff + {8'h00, req_rx_byte};
         end
         fill_in = fill_ff + FILL_W'(1);
         if (fill_ff == LAST_POS) begin
            csum_match = (~sum_ff == {req_rx_byte, prev_ff});
         end
      end
   end

   assign quiet_in = (quiet_ff == QUIET_MAX) ? quiet_ff : quiet_ff + 17'd1;

   assign status.frame_good   = !req_op && csum_match;
   assign status.fail_fire    = req_op && link_up_ff && (quiet_in > {1'b0, timeout_ff});
   assign status.conn_pending = conn_pending_ff;
   assign status.out_free     = !rsp_valid_ff || rsp_ready;
   assign status.ch_last      = (ch_ff == CH_W'(NUM_CHANNELS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff      <= TIMEOUT_RST;
         fill_ff         <= '0;
         sum_ff          <= '0;
         link_up_ff      <= 1'b0;
         conn_pending_ff <= 1'b0;
         quiet_ff        <= '0;
         ch_ff           <= '0;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         if (byte_acc) begin
            fill_ff <= fill_in;
            sum_ff  <= sum_in;
            if (status.frame_good) begin
               quiet_ff        <= '0;
               link_up_ff      <= 1'b1;
               conn_pending_ff <= !link_up_ff;
            end
         end
         if (tick_acc) begin
            quiet_ff <= quiet_in;
            if (status.fail_fire) begin
               link_up_ff <= 1'b0;
            end
         end
         if (cmd.ch_clr) begin
            ch_ff <= '0;
         end else if (cmd.ch_inc) begin
            ch_ff <= ch_ff + CH_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (byte_acc) begin
         prev_ff <= req_rx_byte;
      end
   end

   assign rd_addr = {ch_ff, 1'b0} + (cmd.rd_hi ? FILL_W'(3) : FILL_W'(2));

   rcfr_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_BYTES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (byte_acc),
      .wr_addr (fill_ff),
      .wr_data (req_rx_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // pulse scaling: clamp, magnitude, *32767, /500, round half to even
   assign pulse   = {rd_data, lo_ff};
   assign clamped = (pulse < PULSE_MIN) ? PULSE_MIN[10:0] :
                    (pulse > PULSE_MAX) ? PULSE_MAX[10:0] : pulse[10:0];

   assign recip_prod = 49'(prod_ff) * 49'(RECIP);
   assign rem        = prod_ff - 24'(quot_ff) * SCALE_DEN;

   always_comb begin
      rounded = {1'b0, quot_ff};
      if (rem > HALF_DEN || (rem == HALF_DEN && quot_ff[0])) begin
         rounded = {1'b0, quot_ff} + 16'd1;
      end
      if (rounded > VALUE_MAX) begin
         rounded = VALUE_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_lo) begin
         lo_ff <= rd_data;
      end
      if (cmd.cap_hi) begin
         neg_ff <= clamped < PULSE_MID;
         mag_ff <= (clamped < PULSE_MID) ? 9'(PULSE_MID - clamped) : 9'(clamped - PULSE_MID);
      end
      prod_ff <= {mag_ff, 15'd0} - 24'(mag_ff);
      quot_ff <= recip_prod[RECIP_SHIFT +: 15];
      val_ff  <= neg_ff ? 16'(-rounded) : rounded;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         kind_ff    <= cmd.out_kind;
         last_ff    <= cmd.out_last;
         channel_ff <= (cmd.out_kind == KIND_CHANNEL) ? ch_ff : '0;
         value_ff   <= (cmd.out_kind == KIND_CHANNEL) ? val_ff : '0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_kind    = kind_ff;
   assign rsp_channel = channel_ff;
   assign rsp_value   = value_ff;
   assign rsp_last    = last_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken transaction");

   a_good_frame_link: assert property (@(posedge clock) disable iff (reset)
      (byte_acc && status.frame_good) |=> (link_up_ff && quiet_ff == '0))
      else $error("good frame did not restore link");

   a_failsafe_drops: assert property (@(posedge clock) disable iff (reset)
      (tick_acc && status.fail_fire) |=> !link_up_ff)
      else $error("failsafe left link up");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff == KIND_CHANNEL) |-> (value_ff != 16'h8000))
      else $error("channel value out of range");

   a_event_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff != KIND_CHANNEL) |-> (value_ff == '0 && channel_ff == '0 && last_ff))
      else $error("link event carries channel data");

endmodule
`default_nettype wire

>>> hdl/rc_channel_frame_receiver_top.sv
`default_nettype none
// -----------------------------------------------------------------------------
// rc_channel_frame_receiver_top
// Serial RC frame receiver: header sync, checksum, channel scaling, link watch.
// -----------------------------------------------------------------------------
// A tick or a byte that does not end a frame is handled in ST_IDLE alone; a tick
// that raises failsafe also passes through ST_EMIT_FAIL. A byte that completes a
// good 32-byte frame starts the channel loop, followed by a connect transaction
// if the link was down: each channel needs two reads of the single-read-port
// frame RAM and three registered steps of scaling (multiply by 32767, reciprocal
// divide by 500, round and sign), and waits in ST_EMIT_CH while results stall.
// The result register lets the next item in while the final transaction is
// still waiting. No clearing pass after reset.
// -----------------------------------------------------------------------------
module rc_channel_frame_receiver_top import rcfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   rcfr_req_if.sink    req_ch,
   rcfr_rsp_if.source  rsp_ch
);

   cmd_type    cmd;
   status_type status;

   rcfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rcfr_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_op      (req_ch.op),
      .req_rx_byte (req_ch.rx_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .rsp_kind    (rsp_ch.kind),
      .rsp_channel (rsp_ch.channel),
      .rsp_value   (rsp_ch.value),
      .rsp_last    (rsp_ch.last)
   );

endmodule
`default_nettype wire

>>> tb/rc_channel_frame_receiver_top_test.sv
`default_nettype none
// -----------------------------------------------------------------------------
// rc_channel_frame_receiver_top_test
// Self-checking bench for the RC channel frame receiver.
// -----------------------------------------------------------------------------
// A table of directed steps covers the following:
//  - header hunting and re-anchoring
//  - pulse clamping and scaling extremes
//  - bad checksums
//  - the reset, zero and maximum timeouts, with quiet-time saturation
// Random phases follow. They are mostly well-formed frames with random pulses,
// mixed with broken frames, tick bursts and line noise, under four patterns of
// sender gaps and receiver stalls. Every result transaction is compared with
// a behavioral predictor of the receiver, or with the value typed in the
// table.
// -----------------------------------------------------------------------------
module rc_channel_frame_receiver_top_test import rcfr_pkg::*;;

   localparam int          FRAME_LATENCY = 2 + 7 * NUM_CHANNELS + 30;
   localparam longint      CYCLE_LIMIT   = 1000000;
   localparam int          PHASES        = 4;
   localparam logic [15:0] PULSE_MID16   = 16'(PULSE_MID);

   typedef struct packed {
      kind_type           kind;
      logic [3:0]         channel;
      logic signed [15:0] value;
      logic               last;
   } chan_event_type;

   typedef enum logic [1:0] {
      STEP_BYTE,
      STEP_FRAME,
      STEP_TICKS,
      STEP_TIMEOUT
   } step_kind_type;

   // arg: byte, pulse (-1 = random per channel), tick count or timeout
   typedef struct packed {
      step_kind_type      what;
      int                 arg;
      bit                 corrupt;
      bit                 typed;
      logic signed [15:0] exp_value;
      bit                 exp_conn;
      bit                 exp_fail;
   } step_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   rcfr_req_if req_ch ();
   rcfr_rsp_if rsp_ch ();

   rc_channel_frame_receiver_top DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver-side state mirror
   logic [5:0]  hunt_fill;
   logic [7:0]  frame_bytes [FRAME_BYTES];
   logic [15:0] frame_sum;
   logic        link_up;
   logic [16:0] quiet_ms;
   logic [15:0] timeout_ms;

   chan_event_type step_events [$];
   chan_event_type typed_events [$];
   chan_event_type pending_events [$];
   logic [15:0]    frame_pulses [NUM_CHANNELS];

   int          send_gap_pct = 0;
   int          rsp_stall_pct = 0;
   int          errors = 0;
   int          items_sent = 0;
   int          ticks_sent = 0;
   int          good_frames = 0;
   int          results_checked = 0;
   int          link_events = 0;
   int          timeout_writes = 0;
   longint      cycle_count = 0;

   function automatic chan_event_type make_event(input kind_type k, input logic [3:0] ch,
                                                 input logic signed [15:0] v);
      chan_event_type e;
      e.kind    = k;
      e.channel = ch;
      e.value   = v;
      e.last    = 1'b0;
      return e;
   endfunction

   // clamp to 1000..2000, scale to +-32767, round half to even
   function automatic logic signed [15:0] pulse_position(input logic [15:0] pulse);
      int unsigned p;
      int unsigned mag;
      int unsigned q;
      int unsigned r;
      bit          neg;
      p = pulse;
      if (p < PULSE_MIN) p = PULSE_MIN;
      if (p > PULSE_MAX) p = PULSE_MAX;
      neg = p < PULSE_MID;
      mag = (neg ? PULSE_MID - p : p - PULSE_MID) * VALUE_MAX;
      q = mag / SCALE_DEN;
      r = mag % SCALE_DEN;
      if (r > HALF_DEN || (r == HALF_DEN && q[0])) q++;
      if (q > VALUE_MAX) q = VALUE_MAX;
      return neg ? 16'(-int'(q)) : 16'(q);
   endfunction

   function automatic void frame_rx_reset();
      hunt_fill  = '0;
      frame_sum  = '0;
      link_up    = 1'b0;
      quiet_ms   = '0;
      timeout_ms = TIMEOUT_RST;
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
   endfunction

   function automatic void frame_rx_step(input logic op, input logic [7:0] b);
      logic [4:0]  pos;
      logic [15:0] pulse;
      step_events.delete();
      if (op) begin
         if (quiet_ms != QUIET_MAX) quiet_ms++;
         if (link_up && quiet_ms > {1'b0, timeout_ms}) begin
            link_up = 1'b0;
            step_events.push_back(make_event(KIND_FAILSAFE, '0, '0));
         end
      end else if (hunt_fill == 6'd0) begin
         if (b == HDR0) begin
            frame_bytes[0] = b;
            frame_sum = 16'(b);
            hunt_fill = 6'd1;
         end
      end else if (hunt_fill == 6'd1) begin
         if (b == HDR1) begin
            frame_bytes[1] = b;
            frame_sum = frame_sum + 16'(b);
            hunt_fill = 6'd2;
         end else if (b == HDR0) begin
            frame_bytes[0] = b;
            frame_sum = 16'(b);
         end else begin
            hunt_fill = 6'd0;
         end
      end else begin
         pos = hunt_fill[4:0];
         frame_bytes[pos] = b;
         if (pos < CSUM_POS) frame_sum = frame_sum + 16'(b);
         hunt_fill = {1'b0, pos} + 6'd1;
         if (hunt_fill == FRAME_BYTES) begin
            hunt_fill = 6'd0;
            if (16'hFFFF - frame_sum == {frame_bytes[LAST_POS], frame_bytes[CSUM_POS]}) begin
               good_frames++;
               for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                  pulse = {frame_bytes[3 + 2 * ch], frame_bytes[2 + 2 * ch]};
                  step_events.push_back(make_event(KIND_CHANNEL, 4'(ch),
                                                   pulse_position(pulse)));
               end
               quiet_ms = '0;
               if (!link_up) begin
                  link_up = 1'b1;
                  step_events.push_back(make_event(KIND_CONNECT, '0, '0));
               end
            end
         end
      end
      if (step_events.size() != 0) step_events[step_events.size() - 1].last = 1'b1;
   endfunction

   function automatic void typed_from_step(input step_type s);
      typed_events.delete();
      if (s.what == STEP_FRAME && !s.corrupt) begin
         for (int ch = 0; ch < NUM_CHANNELS; ch++)
            typed_events.push_back(make_event(KIND_CHANNEL, 4'(ch), s.exp_value));
         if (s.exp_conn) typed_events.push_back(make_event(KIND_CONNECT, '0, '0));
      end else if (s.what == STEP_TICKS && s.exp_fail) begin
         typed_events.push_back(make_event(KIND_FAILSAFE, '0, '0));
      end
      if (typed_events.size() != 0) typed_events[typed_events.size() - 1].last = 1'b1;
   endfunction

   function automatic logic [15:0] rand_pulse();
      case ($urandom_range(3, 0))
         0:       return 16'($urandom);
         1:       return 16'($urandom_range(PULSE_MAX, PULSE_MIN));
         2:       return $urandom_range(1, 0) ? 16'($urandom_range(PULSE_MIN + 10, PULSE_MIN - 10))
                                              : 16'($urandom_range(PULSE_MAX + 10, PULSE_MAX - 10));
         default: return PULSE_MID16 + 16'($urandom_range(500, 0)) - 16'd250;
      endcase
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(2, 0))
         0:       return HDR0;
         1:       return HDR1;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic push_item(input logic op, input logic [7:0] b, input bit typed);
      while (send_gap_pct != 0 && $urandom_range(99, 0) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.op      <= op;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      frame_rx_step(op, b);
      items_sent++;
      if (op) ticks_sent++;
      if (typed) begin
         foreach (typed_events[i]) pending_events.push_back(typed_events[i]);
      end else begin
         foreach (step_events[i]) pending_events.push_back(step_events[i]);
      end
   endtask

   task automatic send_ticks(input int count, input bit typed);
      for (int k = 0; k < count; k++) push_item(1'b1, 8'($urandom), typed && k == count - 1);
   endtask

   // sends the first cut bytes of a frame built from frame_pulses
   task automatic send_frame(input bit corrupt, input int cut, input bit typed);
      logic [7:0]  fb [FRAME_BYTES];
      logic [15:0] sum;
      fb[0] = HDR0;
      fb[1] = HDR1;
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         fb[2 + 2 * ch] = frame_pulses[ch][7:0];
         fb[3 + 2 * ch] = frame_pulses[ch][15:8];
      end
      sum = '0;
      for (int i = 0; i < CSUM_POS; i++) sum = sum + 16'(fb[i]);
      sum = 16'hFFFF - sum;
      fb[CSUM_POS] = sum[7:0];
      fb[LAST_POS] = sum[15:8];
      if (corrupt) fb[CSUM_POS + $urandom_range(1, 0)] ^= 8'(1 << $urandom_range(7, 0));
      for (int i = 0; i < cut; i++) push_item(1'b0, fb[i], typed && i == FRAME_BYTES - 1);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      wait (pending_events.size() == 0);
      repeat (FRAME_LATENCY) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [15:0] ms);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ms;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      timeout_ms = ms;
      timeout_writes++;
   endtask

   step_type plan [31] = '{
      '{STEP_TICKS,   3,           0, 1, 16'sd0,      0, 0},
      '{STEP_BYTE,    255,         0, 0, 16'sd0,      0, 0},
      '{STEP_BYTE,    0,           0, 0, 16'sd0,      0, 0},
      '{STEP_BYTE,    int'(HDR1),  0, 0, 16'sd0,      0, 0},
      '{STEP_FRAME,   1500,        0, 1, 16'sd0,      1, 0},
      '{STEP_FRAME,   1000,        0, 1, -16'sd32767, 0, 0},
      '{STEP_FRAME,   2000,        0, 1, 16'sd32767,  0, 0},
      '{STEP_FRAME,   0,           0, 1, -16'sd32767, 0, 0},
      '{STEP_FRAME,   65535,       0, 1, 16'sd32767,  0, 0},
      '{STEP_FRAME,   1750,        0, 0, 16'sd0,      0, 0},
      '{STEP_FRAME,   -1,          0, 0, 16'sd0,      0, 0},
      '{STEP_FRAME,   1500,        1, 1, 16'sd0,      0, 0},
      '{STEP_BYTE,    int'(HDR0),  0, 0, 16'sd0,      0, 0},
      '{STEP_FRAME,   1250,        0, 0, 16'sd0,      0, 0},
      '{STEP_BYTE,    int'(HDR0),  0, 0, 16'sd0,      0, 0},
      '{STEP_BYTE,    65,          0, 0, 16'sd0,      0, 0},
      '{STEP_FRAME,   -1,          0, 0, 16'sd0,      0, 0},
      '{STEP_TICKS,   1000,        0, 1, 16'sd0,      0, 0},
      '{STEP_TICKS,   1,           0, 1, 16'sd0,      0, 1},
      '{STEP_TICKS,   2,           0, 1, 16'sd0,      0, 0},
      '{STEP_TIMEOUT, 0,           0, 0, 16'sd0,      0, 0},
      '{STEP_FRAME,   1500,        0, 1, 16'sd0,      1, 0},
      '{STEP_TICKS,   1,           0, 1, 16'sd0,      0, 1},
      '{STEP_TIMEOUT, 65535,       0, 0, 16'sd0,      0, 0},
      '{STEP_FRAME,   -1,          0, 0, 16'sd0,      0, 0},
      '{STEP_TICKS,   65536,       0, 1, 16'sd0,      0, 1},
      '{STEP_TICKS,   65540,       0, 1, 16'sd0,      0, 0},
      '{STEP_FRAME,   1999,        0, 0, 16'sd0,      0, 0},
      '{STEP_TIMEOUT, 1,           0, 0, 16'sd0,      0, 0},
      '{STEP_TICKS,   1,           0, 1, 16'sd0,      0, 0},
      '{STEP_TICKS,   1,           0, 1, 16'sd0,      0, 1}
   };

   int gap_by_phase   [PHASES] = '{0, 65, 0, 21};
   int stall_by_phase [PHASES] = '{0, 0, 65, 21};

   always @(posedge clock) begin
      rsp_ch.ready <= (rsp_stall_pct == 0) || ($urandom_range(99, 0) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      chan_event_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_events.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction kind=%0d channel=%0d value=%0d last=%0b",
                     $time, rsp_ch.kind, rsp_ch.channel, rsp_ch.value, rsp_ch.last);
         end else begin
            want = pending_events.pop_front();
            results_checked++;
            if (want.kind != KIND_CHANNEL) link_events++;
            if (rsp_ch.kind !== want.kind || rsp_ch.channel !== want.channel ||
                rsp_ch.value !== want.value || rsp_ch.last !== want.last) begin
               errors++;
               $display("%0t: mismatch expected kind=%0d channel=%0d value=%0d last=%0b",
                        $time, want.kind, want.channel, want.value, want.last);
               $display("%0t:          actual kind=%0d channel=%0d value=%0d last=%0b",
                        $time, rsp_ch.kind, rsp_ch.channel, rsp_ch.value, rsp_ch.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run stopped after %0d cycles, %0d results outstanding",
                  $time, cycle_count, pending_events.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      step_type row;
      int       phase_items;
      int       phase_good;
      int       pick;
      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= '0;
      req_ch.valid   <= 1'b0;
      req_ch.op      <= 1'b0;
      req_ch.rx_byte <= '0;
      frame_rx_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         row = plan[i];
         if (row.typed) typed_from_step(row);
         case (row.what)
            STEP_BYTE:    push_item(1'b0, 8'(row.arg), row.typed);
            STEP_TICKS:   send_ticks(row.arg, row.typed);
            STEP_TIMEOUT: write_timeout(16'(row.arg));
            STEP_FRAME: begin
               foreach (frame_pulses[ch])
                  frame_pulses[ch] = (row.arg < 0) ? rand_pulse() : 16'(row.arg);
               send_frame(row.corrupt, FRAME_BYTES, row.typed);
            end
            default: begin
            end
         endcase
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         write_timeout(16'($urandom_range(6, 0)));
         send_gap_pct  = gap_by_phase[ph];
         rsp_stall_pct = stall_by_phase[ph];
         phase_items   = items_sent;
         phase_good    = good_frames;
         while (items_sent - phase_items < 40 || good_frames - phase_good < 2) begin
            if ($urandom_range(19, 0) == 0) settle();
            pick = $urandom_range(99, 0);
            foreach (frame_pulses[ch]) frame_pulses[ch] = rand_pulse();
            if (pick < 60)
               send_frame(1'b0, FRAME_BYTES, 1'b0);
            else if (pick < 70)
               send_frame(1'b1, FRAME_BYTES, 1'b0);
            else if (pick < 75)
               send_frame(1'b0, $urandom_range(FRAME_BYTES - 1, 2), 1'b0);
            else if (pick < 90)
               send_ticks($urandom_range(int'(timeout_ms) + 3, 1), 1'b0);
            else
               repeat ($urandom_range(4, 1)) push_item(1'b0, noise_byte(), 1'b0);
         end
      end

      settle();
      if (pending_events.size() != 0) begin
         errors += pending_events.size();
         $display("%0t: %0d expected transactions never arrived", $time, pending_events.size());
      end
      $display("Sent %0d items (%0d ticks), %0d good frames, %0d timeout settings.",
               items_sent, ticks_sent, good_frames, timeout_writes);
      $display("Checked %0d result transactions, %0d of them link events.",
               results_checked, link_events);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
`default_nettype wire
